// ===== src/vst_pkg.sv =====
// Shared types, codes and helpers for the velocity setpoint tracker.
// No dependencies; used by velocity_setpoint_tracker.
`default_nettype none
package vst_pkg;

    typedef enum logic [2:0] {
        OP_ODOM  = 3'd0,
        OP_GOAL  = 3'd1,
        OP_PLAN  = 3'd2,
        OP_TICK  = 3'd3,
        OP_LINK  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        REG_GAIN  = 2'd0,
        REG_BLEND = 2'd1,
        REG_LIMIT = 2'd2,
        REG_ALT   = 2'd3
    } t_reg;

    // Saturate a 43 bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [31:0] res;
        if (v[42:31] == {12{v[42]}}) begin
            res = v[31:0];
        end else if (v[42]) begin
            res = {1'b1, 31'd0};
        end else begin
            res = {1'b0, {31{1'b1}}};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/velocity_setpoint_tracker.sv =====
// Velocity setpoint tracker: proportional position control with planner feedforward.
// Uses vst_pkg, vst_mul, vst_sqrt and vst_div.
//
// Usage:
//  - Request channel: i_in_valid / o_in_stall with op and payload fields. Odometry,
//    goal-seen, planner and link requests update state in the cycle they are taken.
//  - A tick with the link up starts one command computation; o_in_stall stays high
//    until that command is taken on the result channel (o_out_valid / i_out_stall).
//  - All arithmetic runs on one shared registered multiplier under a small
//    sequencer: 5 gain/blend products, 3 squares, a square root, and, only when
//    the magnitude exceeds the limit, per component one product and a divide.
//  - Without limiting, the command is ready once the square root is done; otherwise
//    each component is scaled in turn first. Other requests do not raise o_in_stall.
//  - A stalled result holds on the output ports; no new request is taken meanwhile.
//  - Reset (synchronous, active low) clears all tracked state and loads the
//    register defaults. Configuration writes are taken at any edge with i_cfg_we.
`default_nettype none
module velocity_setpoint_tracker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_op,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_planner_vel_x,
    input  wire logic signed [31:0] i_planner_vel_y,
    input  wire logic signed [14:0] i_heading,
    input  wire logic               i_link_connected,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_cmd_vel_x,
    output logic signed [31:0]      o_cmd_vel_y,
    output logic signed [31:0]      o_cmd_vel_z,
    output logic signed [14:0]      o_cmd_heading,
    output logic                    o_tracking
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_MAC       = 9'b000000010,
        S_SQ        = 9'b000000100,
        S_SQRT_GO   = 9'b000001000,
        S_SQRT_WAIT = 9'b000010000,
        S_SMUL      = 9'b000100000,
        S_DIV_GO    = 9'b001000000,
        S_DIV_WAIT  = 9'b010000000,
        S_OUT       = 9'b100000000
    } t_state;

    t_state r_state;
    logic [2:0] r_cnt;
    logic [1:0] r_j;

    // configuration
    logic [15:0]        r_gain, r_blend;
    logic [30:0]        r_limit;
    logic signed [31:0] r_alt;

    // tracked state
    logic signed [31:0] r_hold_x, r_hold_y, r_cur_x, r_cur_y, r_cur_z;
    logic signed [31:0] r_plan_x, r_plan_y, r_plan_z, r_plan_vx, r_plan_vy;
    logic signed [14:0] r_hold_hd, r_plan_hd;
    logic r_latched, r_goal, r_link;

    // working registers
    logic signed [31:0] r_v [3];
    logic signed [50:0] r_acc;
    logic [63:0]        r_sum;
    logic [32:0]        r_mag;

    logic signed [32:0] w_a, w_b, w_ex, w_ey, w_ez;
    logic signed [65:0] w_prod;
    logic signed [50:0] w_raw;
    logic [31:0]        w_abs;
    logic               w_accept, w_sq_go, w_div_go, w_sq_done, w_div_done;
    logic [32:0]        w_root;
    logic [31:0]        w_quo;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd_vel_x = r_v[0];
    assign o_cmd_vel_y = r_v[1];
    assign o_cmd_vel_z = r_v[2];
    assign w_sq_go  = (r_state == S_SQRT_GO);
    assign w_div_go = (r_state == S_DIV_GO);

    // position errors toward hold point (altitude register for z) or planner position
    assign w_ex = r_goal ? (33'(r_plan_x) - 33'(r_cur_x)) : (33'(r_hold_x) - 33'(r_cur_x));
    assign w_ey = r_goal ? (33'(r_plan_y) - 33'(r_cur_y)) : (33'(r_hold_y) - 33'(r_cur_y));
    assign w_ez = r_goal ? (33'(r_plan_z) - 33'(r_cur_z)) : (33'(r_alt) - 33'(r_cur_z));
    assign w_abs = r_v[r_j][31] ? 32'(-33'(r_v[r_j])) : 32'(r_v[r_j]);
    assign w_raw = r_acc + w_prod[50:0];

    // operand select for the shared multiplier
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            S_MAC: begin
                case (r_cnt)
                    3'd0: begin w_a = w_ex; w_b = {17'd0, r_gain}; end
                    3'd1: begin
                        w_a = r_goal ? 33'(r_plan_vx) : '0;
                        w_b = {17'd0, r_blend};
                    end
                    3'd2: begin w_a = w_ey; w_b = {17'd0, r_gain}; end
                    3'd3: begin
                        w_a = r_goal ? 33'(r_plan_vy) : '0;
                        w_b = {17'd0, r_blend};
                    end
                    3'd4: begin w_a = w_ez; w_b = {17'd0, r_gain}; end
                    default: ;
                endcase
            end
            S_SQ: begin
                if (r_cnt < 3'd3) begin
                    w_a = 33'(r_v[r_cnt[1:0]]);
                    w_b = 33'(r_v[r_cnt[1:0]]);
                end
            end
            S_SMUL: begin
                w_a = {1'b0, w_abs};
                w_b = {2'b0, r_limit};
            end
            default: ;
        endcase
    end

    vst_mul u_mul (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .o_p(w_prod));

    vst_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_go), .i_x(r_sum),
        .o_done(w_sq_done), .o_root(w_root)
    );

    vst_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_go), .i_dvd(w_prod[63:0]),
        .i_dvs(r_mag), .o_done(w_div_done), .o_quo(w_quo)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= 16'd154;
            r_blend <= 16'd128;
            r_limit <= 31'd78643;
            r_alt   <= 32'sd65536;
        end else if (i_cfg_we) begin
            unique case (vst_pkg::t_reg'(i_cfg_idx))
                vst_pkg::REG_GAIN:  r_gain  <= i_cfg_data[15:0];
                vst_pkg::REG_BLEND: r_blend <= i_cfg_data[15:0];
                vst_pkg::REG_LIMIT: r_limit <= i_cfg_data[30:0];
                vst_pkg::REG_ALT:   r_alt   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tracked state: update on non-tick requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_x <= '0; r_hold_y <= '0; r_hold_hd <= '0; r_latched <= 1'b0;
            r_cur_x <= '0; r_cur_y <= '0; r_cur_z <= '0; r_goal <= 1'b0;
            r_plan_x <= '0; r_plan_y <= '0; r_plan_z <= '0;
            r_plan_vx <= '0; r_plan_vy <= '0; r_plan_hd <= '0; r_link <= 1'b0;
        end else if (w_accept) begin
            case (vst_pkg::t_op'(i_op))
                vst_pkg::OP_ODOM: begin
                    // latch the hold point once, track current position always
                    if (!r_latched) begin
                        r_hold_x  <= i_pos_x;
                        r_hold_y  <= i_pos_y;
                        r_hold_hd <= i_heading;
                        r_latched <= 1'b1;
                    end
                    r_cur_x <= i_pos_x; r_cur_y <= i_pos_y; r_cur_z <= i_pos_z;
                end
                vst_pkg::OP_GOAL: r_goal <= 1'b1;
                vst_pkg::OP_PLAN: begin
                    r_plan_x <= i_pos_x; r_plan_y <= i_pos_y; r_plan_z <= i_pos_z;
                    r_plan_vx <= i_planner_vel_x; r_plan_vy <= i_planner_vel_y;
                    r_plan_hd <= i_heading;
                end
                vst_pkg::OP_LINK: r_link <= i_link_connected;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_j     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && vst_pkg::t_op'(i_op) == vst_pkg::OP_TICK && r_link) begin
                        r_state <= S_MAC;
                        r_cnt   <= '0;
                    end
                end
                S_MAC: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd5) begin
                        r_state <= S_SQ;
                        r_cnt   <= '0;
                    end
                end
                S_SQ: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd3) begin
                        r_state <= S_SQRT_GO;
                    end
                end
                S_SQRT_GO: r_state <= S_SQRT_WAIT;
                S_SQRT_WAIT: begin
                    if (w_sq_done) begin
                        r_j <= '0;
                        r_state <= ({2'b0, r_limit} < w_root) ? S_SMUL : S_OUT;
                    end
                end
                S_SMUL:   r_state <= S_DIV_GO;
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        if (r_j == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_SMUL;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            o_cmd_heading <= r_goal ? r_plan_hd : r_hold_hd;
            o_tracking    <= r_goal;
        end
        if (r_state == S_MAC) begin
            // accumulate products issued in the previous cycle
            case (r_cnt)
                3'd1, 3'd3: r_acc <= w_prod[50:0];
                3'd2: r_v[0] <= vst_pkg::sat32(w_raw[50:8]);
                3'd4: r_v[1] <= vst_pkg::sat32(w_raw[50:8]);
                3'd5: r_v[2] <= vst_pkg::sat32(w_prod[50:8]);
                default: ;
            endcase
        end
        if (r_state == S_SQ) begin
            if (r_cnt == 3'd1) begin
                r_sum <= w_prod[63:0];
            end else if (r_cnt != 3'd0) begin
                r_sum <= r_sum + w_prod[63:0];
            end
        end
        if (r_state == S_SQRT_WAIT && w_sq_done) begin
            r_mag <= w_root;
        end
        if (r_state == S_DIV_WAIT && w_div_done) begin
            r_v[r_j] <= r_v[r_j][31] ? -$signed(w_quo) : $signed(w_quo);
        end
    end

endmodule
`default_nettype wire

// ===== src/vst_mul.sv =====
// Shared 33 x 33 signed multiplier with a registered product.
// Depends on nothing.
`default_nettype none
module vst_mul (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed [65:0]      o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule
`default_nettype wire

// ===== src/vst_sqrt.sv =====
// Iterative floor square root of a 64 bit value, one result bit per cycle.
// Depends on nothing.
`default_nettype none
module vst_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_x,
    output logic             o_done,
    output logic [32:0]      o_root
);
    logic [63:0] r_x, r_r, r_bit;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [64:0] w_sum;

    assign w_sum  = {1'b0, r_r} + {1'b0, r_bit};
    assign o_root = r_r[32:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_r   <= '0;
            r_bit <= 64'd1 << 62;
        end else if (r_busy) begin
            if ({1'b0, r_x} >= w_sum) begin
                r_x <= r_x - w_sum[63:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end
endmodule
`default_nettype wire

// ===== src/vst_div.sv =====
// Iterative restoring divider: 64 bit dividend by 33 bit divisor, 32 bit quotient.
// The caller guarantees the quotient fits in 32 bits. Depends on nothing.
`default_nettype none
module vst_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dvd,
    input  wire logic [32:0] i_dvs,
    output logic             o_done,
    output logic [31:0]      o_quo
);
    logic [33:0] r_rem;
    logic [31:0] r_low;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [34:0] w_t;

    assign w_t = {r_rem, r_low[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b0, i_dvd[63:32]};
            r_low <= i_dvd[31:0];
            o_quo <= '0;
        end else if (r_busy) begin
            if (w_t >= {2'b0, i_dvs}) begin
                r_rem <= 34'(w_t - {2'b0, i_dvs});
                o_quo <= {o_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_t[33:0];
                o_quo <= {o_quo[30:0], 1'b0};
            end
            r_low <= {r_low[30:0], 1'b0};
        end
    end
endmodule
`default_nettype wire
